[rtl/lwv_pkg.sv]
// Shared types and constants for the 3x3 local variance block.
// Used by lwv_front, lwv_lane and the top level; depends on nothing.
package lwv_pkg;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int FW_W      = 11;
    localparam int FH_W      = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int VAR_W     = 18;
    localparam int SMP_W     = 8;
    localparam int IO_CH     = 3;
    localparam int PIX_W     = SMP_W * IO_CH;
    localparam int WCL_W     = 14;
    localparam int SUM_W     = 12;
    localparam int SQ_W      = 20;
    localparam int NQ_W      = 24;
    localparam int DIFF_W    = 23;
    localparam int RECIP_W   = 32;
    localparam int PROD_W    = DIFF_W + 4 + RECIP_W;
    localparam int QUO_LSB   = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX = 13'd4096;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        NC_FOUR,
        NC_SIX,
        NC_NINE
    } ncode_t;

    // Reciprocals of n*n scaled by 2^QUO_LSB, rounded up. Exact for every
    // numerator this block can produce.
    function automatic logic [RECIP_W-1:0] recip(input ncode_t nc);
        logic [RECIP_W-1:0] m;
        case (nc)
            NC_FOUR: m = 32'd2147483648;
            NC_SIX:  m = 32'd954437177;
            NC_NINE: m = 32'd424194301;
            default: m = '0;
        endcase
        return m;
    endfunction

    typedef logic [IO_CH-1:0][SMP_W-1:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col3_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             fe;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        col3_t [2:0]      win;
    } job_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             fe;
    } meta_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

    typedef struct packed {
        logic             op;
        logic [SMP_W-1:0] chan_zero;
        logic [SMP_W-1:0] chan_one;
        logic [SMP_W-1:0] chan_two;
    } lwv_in_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [VAR_W-1:0] var_zero;
        logic [VAR_W-1:0] var_one;
        logic [VAR_W-1:0] var_two;
        logic             frame_end;
    } lwv_out_t;

endpackage

[rtl/lwv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
module lwv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/lwv_front.sv]
// Raster front end: line stores, window columns, position counters and drain flush.
// Turns each accepted item into zero, one or two window jobs. Depends on lwv_pkg, lwv_ram.
module lwv_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int LANES     = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lwv_pkg::FW_W-1:0]   frame_width,
    input  logic [lwv_pkg::FH_W-1:0]   frame_height,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  lwv_pkg::lwv_in_t           in_item,
    input  logic                       s1_free,
    output logic                       s1_valid,
    output lwv_pkg::job_t              s1_job
);
    import lwv_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = SMP_W * LANES;
    localparam int RW = 2 * PW;

    function automatic pix_t widen(input logic [PW-1:0] v);
        return pix_t'(PIX_W'(v));
    endfunction

    function automatic logic [AW-1:0] clamp_idx(input logic [WCL_W-1:0] v);
        if (v >= WCL_W'(MAX_WIDTH - 1))
            return AW'(MAX_WIDTH - 1);
        else
            return AW'(v);
    endfunction

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] dcnt_reg, dcnt_next;
    logic             pend_reg, pend_next;
    logic [ROW_W-1:0] drow_reg, drow_next;
    logic [AW:0]      clr_reg;
    logic             s1_v_reg, s1_v_next;
    job_t             s1_reg, s1_next;
    logic             j2_v_reg, j2_v_next;
    job_t             j2_reg, j2_next;
    col3_t            wc0_reg, wc1_reg;
    col3_t            lat0_reg, lat1_reg;
    col3_t            dl_reg, dc_reg, dr_reg;
    logic             wq_en_reg;
    logic [AW-1:0]    wq_addr_reg, rbq_addr_reg;
    logic [RW-1:0]    wq_data_reg;

    logic [WCL_W-1:0] eff_w;
    logic [FH_W-1:0]  eff_h;
    logic             clr_busy, s1_load_ok, pixel_acc, drain_acc;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             lastcol, last_d, has_a, has_b;
    logic [PW-1:0]    cur_top, cur_mid, cur_new;
    col3_t            cur_c, new_c, portb_c;
    logic [RW-1:0]    portb_raw, rda_data, rdb_data, wr_data;
    logic [AW-1:0]    rda_addr, rdb_addr, wr_addr;
    logic             wr_en;
    job_t             job_a, job_b, job_d;

    always_comb
    begin
        if (frame_width < FW_W'(2))
            eff_w = WCL_W'(2);
        else if (WCL_W'(frame_width) > WCL_W'(MAX_WIDTH))
            eff_w = WCL_W'(MAX_WIDTH);
        else
            eff_w = WCL_W'(frame_width);
        if (frame_height < FH_W'(2))
            eff_h = FH_W'(2);
        else if (frame_height > FRAME_HEIGHT_MAX)
            eff_h = FRAME_HEIGHT_MAX;
        else
            eff_h = frame_height;
    end

    assign clr_busy   = clr_reg < (AW+1)'(MAX_WIDTH);
    assign s1_load_ok = !s1_v_reg || s1_free;
    assign in_ready   = !clr_busy && !j2_v_reg && s1_load_ok;
    assign pixel_acc  = in_valid && in_ready && (in_item.op == OP_PIXEL);
    assign drain_acc  = in_valid && in_ready && (in_item.op == OP_DRAIN) && pend_reg;

    // A pixel that arrives while a flush is pending restarts the frame at the origin.
    assign x       = pend_reg ? '0 : col_reg;
    assign y       = pend_reg ? '0 : row_reg;
    assign lastcol = !pend_reg && (WCL_W'(col_reg) >= eff_w - WCL_W'(1));
    assign last_d  = WCL_W'(dcnt_reg) >= eff_w - WCL_W'(1);
    assign has_a   = (y != '0) && (x != '0);
    assign has_b   = (y != '0) && lastcol;

    assign {cur_top, cur_mid} = rda_data;
    assign cur_new = PW'({in_item.chan_two, in_item.chan_one, in_item.chan_zero});

    always_comb
    begin
        cur_c.top = widen(cur_top);
        cur_c.mid = widen(cur_mid);
        cur_c.bot = widen(cur_new);
        new_c.top = widen(cur_mid);
        new_c.mid = widen(cur_new);
        new_c.bot = '0;
        // Same-address bypass for the flush read port.
        if (wq_en_reg && (wq_addr_reg == rbq_addr_reg))
            portb_raw = wq_data_reg;
        else
            portb_raw = rdb_data;
        portb_c.top = widen(portb_raw[RW-1:PW]);
        portb_c.mid = widen(portb_raw[PW-1:0]);
        portb_c.bot = '0;
    end

    always_comb
    begin
        job_a.col      = x - COL_W'(1);
        job_a.row      = y - ROW_W'(1);
        job_a.fe       = 1'b0;
        job_a.top_ok   = y >= ROW_W'(2);
        job_a.bot_ok   = 1'b1;
        job_a.left_ok  = x >= COL_W'(2);
        job_a.right_ok = 1'b1;
        job_a.win[0]   = wc1_reg;
        job_a.win[1]   = wc0_reg;
        job_a.win[2]   = cur_c;

        job_b.col      = x;
        job_b.row      = y - ROW_W'(1);
        job_b.fe       = 1'b0;
        job_b.top_ok   = y >= ROW_W'(2);
        job_b.bot_ok   = 1'b1;
        job_b.left_ok  = x != '0;
        job_b.right_ok = 1'b0;
        job_b.win[0]   = wc0_reg;
        job_b.win[1]   = cur_c;
        job_b.win[2]   = '0;

        job_d.col      = dcnt_reg;
        job_d.row      = drow_reg;
        job_d.fe       = last_d;
        job_d.top_ok   = drow_reg != '0;
        job_d.bot_ok   = 1'b0;
        job_d.left_ok  = dcnt_reg != '0;
        job_d.right_ok = !last_d;
        job_d.win[0]   = dl_reg;
        job_d.win[1]   = dc_reg;
        job_d.win[2]   = dr_reg;
    end

    always_comb
    begin
        s1_v_next = s1_v_reg;
        s1_next   = s1_reg;
        j2_v_next = j2_v_reg;
        j2_next   = j2_reg;
        if (s1_load_ok)
        begin
            s1_v_next = 1'b0;
            if (j2_v_reg)
            begin
                s1_v_next = 1'b1;
                s1_next   = j2_reg;
                j2_v_next = 1'b0;
            end
            else if (pixel_acc && has_a)
            begin
                s1_v_next = 1'b1;
                s1_next   = job_a;
                if (has_b)
                begin
                    j2_v_next = 1'b1;
                    j2_next   = job_b;
                end
            end
            else if (pixel_acc && has_b)
            begin
                s1_v_next = 1'b1;
                s1_next   = job_b;
            end
            else if (drain_acc)
            begin
                s1_v_next = 1'b1;
                s1_next   = job_d;
            end
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        dcnt_next = dcnt_reg;
        pend_next = pend_reg;
        drow_next = drow_reg;
        if (pixel_acc)
        begin
            pend_next = 1'b0;
            dcnt_next = '0;
            if (lastcol)
            begin
                col_next = '0;
                if (FH_W'(y) >= eff_h - FH_W'(1))
                begin
                    drow_next = y;
                    row_next  = '0;
                    pend_next = 1'b1;
                end
                else
                begin
                    row_next = y + ROW_W'(1);
                end
            end
            else
            begin
                col_next = x + COL_W'(1);
                row_next = y;
            end
        end
        else if (drain_acc)
        begin
            if (last_d)
            begin
                pend_next = 1'b0;
                dcnt_next = '0;
            end
            else
            begin
                dcnt_next = dcnt_reg + COL_W'(1);
            end
        end
    end

    // Port A always prefetches the column of the next pixel, port B the column
    // two ahead of the next flush position.
    assign rda_addr = clamp_idx(WCL_W'(col_next));
    assign rdb_addr = clamp_idx(WCL_W'(dcnt_next) + WCL_W'(2));

    always_comb
    begin
        if (clr_busy)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = pixel_acc;
            wr_addr = clamp_idx(WCL_W'(x));
            wr_data = {cur_mid, cur_new};
        end
    end

    lwv_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rda_addr),
        .rdata (rda_data)
    );

    lwv_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rdb_addr),
        .rdata (rdb_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            dcnt_reg  <= '0;
            pend_reg  <= 1'b0;
            drow_reg  <= '0;
            clr_reg   <= '0;
            s1_v_reg  <= 1'b0;
            j2_v_reg  <= 1'b0;
            wq_en_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            dcnt_reg  <= dcnt_next;
            pend_reg  <= pend_next;
            drow_reg  <= drow_next;
            s1_v_reg  <= s1_v_next;
            j2_v_reg  <= j2_v_next;
            wq_en_reg <= wr_en;
            if (clr_busy)
            begin
                clr_reg <= clr_reg + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        j2_reg       <= j2_next;
        wq_addr_reg  <= wr_addr;
        wq_data_reg  <= wr_data;
        rbq_addr_reg <= rdb_addr;
        if (pixel_acc)
        begin
            wc1_reg <= wc0_reg;
            wc0_reg <= cur_c;
            if (x == COL_W'(0))
            begin
                lat0_reg <= new_c;
            end
            if (x == COL_W'(1))
            begin
                lat1_reg <= new_c;
            end
            // Flush window starts with column zero centred and nothing on its left.
            if (lastcol)
            begin
                dl_reg <= '0;
                dc_reg <= lat0_reg;
                dr_reg <= (x == COL_W'(1)) ? new_c : lat1_reg;
            end
        end
        else if (drain_acc && !last_d)
        begin
            dl_reg <= dc_reg;
            dc_reg <= dr_reg;
            dr_reg <= portb_c;
        end
    end

    assign s1_valid = s1_v_reg;
    assign s1_job   = s1_reg;
endmodule

[rtl/lwv_lane.sv]
// One channel of the variance arithmetic: masked sums, n*Q - S*S, and the
// scaled division by n*n as a reciprocal multiply. Depends on lwv_pkg.
module lwv_lane (
    input  logic                               clk,
    input  lwv_pkg::adv_t                      en,
    input  logic [8:0][lwv_pkg::SMP_W-1:0]     smp,
    input  logic [8:0]                         msk,
    input  lwv_pkg::ncode_t                    nc,
    output logic [lwv_pkg::VAR_W-1:0]          var_q
);
    import lwv_pkg::*;

    logic [SUM_W-1:0]  s_sum, s_reg;
    logic [SQ_W-1:0]   q_sum, q_reg;
    ncode_t            nc2_reg, nc3_reg;
    logic [NQ_W-1:0]   nq, ssq;
    logic [DIFF_W-1:0] d_reg;
    logic [PROD_W-1:0] prod_reg;

    always_comb
    begin
        s_sum = '0;
        q_sum = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (msk[k])
            begin
                s_sum = s_sum + SUM_W'(smp[k]);
                q_sum = q_sum + SQ_W'(smp[k]) * SQ_W'(smp[k]);
            end
        end
    end

    always_comb
    begin
        case (nc2_reg)
            NC_FOUR: nq = NQ_W'({q_reg, 2'b00});
            NC_SIX:  nq = NQ_W'({q_reg, 2'b00}) + NQ_W'({q_reg, 1'b0});
            NC_NINE: nq = NQ_W'({q_reg, 3'b000}) + NQ_W'(q_reg);
            default: nq = '0;
        endcase
        ssq = s_reg * s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s_reg   <= s_sum;
            q_reg   <= q_sum;
            nc2_reg <= nc;
        end
        if (en.s3)
        begin
            d_reg   <= DIFF_W'(nq - ssq);
            nc3_reg <= nc2_reg;
        end
        if (en.s4)
        begin
            prod_reg <= {d_reg, 4'b0000} * recip(nc3_reg);
        end
    end

    assign var_q = prod_reg[QUO_LSB +: VAR_W];
endmodule

[rtl/local_window_variance_3x3.sv]
// Top level of the streaming 3x3 local variance block: configuration registers,
// pipeline control, channel lanes and the output register. Depends on lwv_pkg,
// lwv_front, lwv_lane.
//
//   channel  signals                      direction  payload
//   in       in_valid / in_ready          sink       lwv_in_t (op, three samples)
//   out      out_valid / out_ready        source     lwv_out_t (centre, variances, end)
//   cfg      cfg_we, cfg_index, cfg_data  sink       frame_width, frame_height
//
// One item is taken per clock unless the pipeline stalls; a pixel that ends a row
// below the first carries two results and holds the input while the second moves
// on. A result passes the job, sums, difference, reciprocal product and output
// registers. After reset the line stores are cleared with in_ready low.
// Every stage moves when the one after it is empty or moving, so a stalled output
// still lets items enter until the pipeline is full.
module local_window_variance_3x3 #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lwv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwv_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lwv_pkg::lwv_in_t                in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lwv_pkg::lwv_out_t               out_item
);
    import lwv_pkg::*;

    localparam int LANES = (CHANNELS < IO_CH) ? CHANNELS : IO_CH;

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic            s1_valid;
    job_t            s1_job;
    logic            v2_reg, v3_reg, v4_reg, vo_reg;
    meta_t           m2_reg, m3_reg, m4_reg;
    lwv_out_t        out_reg;
    logic            free_o, free4, free3, free2;
    adv_t            en;
    logic [2:0]      col_ok, row_ok;
    logic [8:0]      msk;
    ncode_t          nc;
    logic [IO_CH-1:0][VAR_W-1:0] lane_var;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    assign free_o = !vo_reg || out_ready;
    assign free4  = !v4_reg || free_o;
    assign free3  = !v3_reg || free4;
    assign free2  = !v2_reg || free3;
    assign en.s2  = free2;
    assign en.s3  = free3;
    assign en.s4  = free4;

    lwv_front #(.MAX_WIDTH(MAX_WIDTH), .LANES(LANES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (fw_reg),
        .frame_height (fh_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .s1_free      (free2),
        .s1_valid     (s1_valid),
        .s1_job       (s1_job)
    );

    // Window size follows from which border rows and columns are present.
    always_comb
    begin
        col_ok = {s1_job.right_ok, 1'b1, s1_job.left_ok};
        row_ok = {s1_job.bot_ok, 1'b1, s1_job.top_ok};
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                msk[3*j+i] = col_ok[j] && row_ok[i];
            end
        end
        if (s1_job.left_ok && s1_job.right_ok && s1_job.top_ok && s1_job.bot_ok)
            nc = NC_NINE;
        else if ((s1_job.left_ok && s1_job.right_ok) || (s1_job.top_ok && s1_job.bot_ok))
            nc = NC_SIX;
        else
            nc = NC_FOUR;
    end

    for (genvar c = 0; c < IO_CH; c++)
    begin : g_lane
        if (c < LANES)
        begin : g_on
            logic [8:0][SMP_W-1:0] smp;
            always_comb
            begin
                for (int j = 0; j < 3; j++)
                begin
                    smp[3*j]   = s1_job.win[j].top[c];
                    smp[3*j+1] = s1_job.win[j].mid[c];
                    smp[3*j+2] = s1_job.win[j].bot[c];
                end
            end
            lwv_lane u_lane (
                .clk   (clk),
                .en    (en),
                .smp   (smp),
                .msk   (msk),
                .nc    (nc),
                .var_q (lane_var[c])
            );
        end
        else
        begin : g_off
            assign lane_var[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (free2)  v2_reg <= s1_valid;
            if (free3)  v3_reg <= v2_reg;
            if (free4)  v4_reg <= v3_reg;
            if (free_o) vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            m2_reg.col <= s1_job.col;
            m2_reg.row <= s1_job.row;
            m2_reg.fe  <= s1_job.fe;
        end
        if (free3)
        begin
            m3_reg <= m2_reg;
        end
        if (free4)
        begin
            m4_reg <= m3_reg;
        end
        if (free_o)
        begin
            out_reg.out_col   <= m4_reg.col;
            out_reg.out_row   <= m4_reg.row;
            out_reg.var_zero  <= lane_var[0];
            out_reg.var_one   <= lane_var[1];
            out_reg.var_two   <= lane_var[2];
            out_reg.frame_end <= m4_reg.fe;
        end
    end

    assign out_valid = vo_reg;
    assign out_item  = out_reg;
endmodule
